// ----- rtl/lpwcd_pkg.sv -----
// Package for the LRU pinned write-back cache directory.
// Holds command, result-kind, status and register codes and the sequencer state type.
// No dependencies.
package lpwcd_pkg;

  localparam logic [3:0] CMD_GET         = 4'd0;
  localparam logic [3:0] CMD_READ        = 4'd1;
  localparam logic [3:0] CMD_WRITE       = 4'd2;
  localparam logic [3:0] CMD_LOCK        = 4'd3;
  localparam logic [3:0] CMD_UNLOCK      = 4'd4;
  localparam logic [3:0] CMD_MARK_DIRTY  = 4'd5;
  localparam logic [3:0] CMD_QUERY       = 4'd6;
  localparam logic [3:0] CMD_INVALIDATE  = 4'd7;
  localparam logic [3:0] CMD_FLUSH       = 4'd8;
  localparam logic [3:0] CMD_FLUSH_EVERY = 4'd9;

  localparam logic [1:0] KIND_DONE      = 2'd0;
  localparam logic [1:0] KIND_WRITEBACK = 2'd1;
  localparam logic [1:0] KIND_FILL      = 2'd2;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_FULL          = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND     = 3'd2;
  localparam logic [2:0] ST_BUSY          = 3'd3;
  localparam logic [2:0] ST_NOT_SUPPORTED = 3'd4;

  localparam logic [1:0] REG_ACTIVE_ENTRIES = 2'd0;
  localparam logic [1:0] REG_WRITER_PRESENT = 2'd1;
  localparam logic [1:0] REG_LOADER_PRESENT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_WB,
    S_FILL,
    S_DONE,
    S_FA_FIND,
    S_FA_EMIT
  } seq_state_t;

endpackage

// ----- rtl/lpwcd_req_if.sv -----
// Command channel interface of the cache directory.
// Depends on nothing.
interface lpwcd_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [63:0] key;
  modport source (output valid, output cmd, output key, input ready);
  modport sink (input valid, input cmd, input key, output ready);
endinterface

// ----- rtl/lpwcd_rsp_if.sv -----
// Result channel interface of the cache directory.
// Depends on nothing.
interface lpwcd_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  slot;
  logic [63:0] target_key;
  logic        zero_fill;
  logic [2:0]  status;
  logic        is_pinned;
  logic        dirty_flag;
  logic        last;
  modport source (output valid, output kind, output slot, output target_key,
                  output zero_fill, output status, output is_pinned, output dirty_flag,
                  output last, input ready);
  modport sink (input valid, input kind, input slot, input target_key,
                input zero_fill, input status, input is_pinned, input dirty_flag,
                input last, output ready);
endinterface

// ----- rtl/lpwcd_cfg_if.sv -----
// Configuration write channel interface of the cache directory.
// Depends on nothing.
interface lpwcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [4:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/lru_pinned_writeback_cache_directory.sv -----
// Top level of the LRU pinned write-back cache directory.
// Depends on lpwcd_pkg, the three channel interfaces and lpwcd_ram.
//
// Usage: a command transaction (cmd, key) enters on req. The block answers on rsp
// with zero or more writeback or fill transactions followed by exactly one done
// transaction that has last set. Configuration transactions on cfg are always
// accepted and must only be issued while the block is idle.
//
// One command is handled at a time; req.ready is high only when the sequencer is
// idle. A lookup scans the active slots through the key RAM, one slot per cycle
// through its registered read port, and stops at the first hit; the sequencer then
// decides and emits the results of the command, done last. The victim search rides
// along with the scan. A flush of every slot walks the LRU ranks one per cycle while
// it finds no dirty slot there, and stops at each dirty slot to emit its writeback,
// waiting there while the receiver stalls.
//
// Results go through a single output register: when the receiver stalls, the
// sequencer waits at its next result until that register is free. Reset clears
// all slot flags and pin counts, sets the LRU ranks to the slot index and restores
// the register defaults; the key RAM is not cleared.
module lru_pinned_writeback_cache_directory
  import lpwcd_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int PIN_BITS = 8
) (
  input logic        clk,
  input logic        rst,
  lpwcd_req_if.sink  req,
  lpwcd_rsp_if.source rsp,
  lpwcd_cfg_if.sink  cfg
);

  localparam int IW  = $clog2(ENTRIES);
  localparam int CAP = (ENTRIES < 16) ? ENTRIES : 16;
  localparam int AW  = $clog2(CAP + 1);
  localparam logic [IW-1:0] TOP_RANK = IW'(ENTRIES - 1);

  // Configuration registers.
  logic [4:0] active_entries;
  logic       writer_present;
  logic       loader_present;

  // Slot state.
  logic                slot_used  [ENTRIES];
  logic                slot_dirty [ENTRIES];
  logic [PIN_BITS-1:0] pin_count  [ENTRIES];
  logic [IW-1:0]       lru_rank   [ENTRIES];

  seq_state_t state, state_next;

  logic [3:0]    cmd_q;
  logic [63:0]   key_q;
  logic [IW-1:0] s_q;
  logic [2:0]    status_q;
  logic          qp_q, qd_q, hit_q;
  logic [63:0]   wb_key;

  logic [AW-1:0] scan_idx;
  logic          cmp_v;
  logic [IW-1:0] cmp_idx;
  logic          free_v, unp_v;
  logic [IW-1:0] free_idx, unp_idx, free_rank, unp_rank;
  logic [63:0]   unp_key;

  logic [IW-1:0] fa_rank, fa_slot, fa_idx;
  logic          fa_any;
  logic [ENTRIES-1:0] fa_match, rank_top;

  logic [AW-1:0] a_cnt;
  logic          out_free, emit;
  logic [1:0]    e_kind;
  logic [IW-1:0] e_slot;
  logic [63:0]   e_key;
  logic          e_zf, e_p, e_d;
  logic [2:0]    e_status;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;

  logic          issue, match, scan_last;
  logic          do_promote, do_op;

  // Active slot count, saturated to 1..CAP.
  always_comb begin
    if (active_entries == 5'd0) begin
      a_cnt = AW'(1);
    end else if (int'(active_entries) > CAP) begin
      a_cnt = AW'(CAP);
    end else begin
      a_cnt = AW'(active_entries);
    end
  end

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);
  assign out_free  = !rsp.valid || rsp.ready;

  assign issue     = (state == S_SCAN) && (scan_idx < a_cnt);
  assign match     = cmp_v && slot_used[cmp_idx] && (ram_rdata == key_q);
  assign scan_last = cmp_v && (cmp_idx == IW'(a_cnt - AW'(1)));

  // Flush-all: find the active, used, dirty slot that holds the current rank.
  always_comb begin
    fa_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      fa_match[i] = (lru_rank[i] == fa_rank) && (i < int'(a_cnt)) &&
                    slot_used[i] && slot_dirty[i];
      rank_top[i] = (lru_rank[i] == TOP_RANK);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (fa_match[i]) begin
        fa_idx = IW'(i);
      end
    end
  end
  assign fa_any = |fa_match;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = IW'(scan_idx);
    if (state == S_SCAN) begin
      ram_re = issue;
    end else if (state == S_FA_FIND) begin
      ram_re    = fa_any;
      ram_raddr = fa_idx;
    end
  end

  lpwcd_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s_q),
    .wdata (key_q),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: next state, result emission and slot update strobes.
  always_comb begin
    state_next = state;
    emit       = 1'b0;
    e_kind     = KIND_DONE;
    e_slot     = s_q;
    e_key      = key_q;
    e_zf       = 1'b0;
    e_status   = ST_OK;
    e_p        = 1'b0;
    e_d        = 1'b0;
    ram_we     = 1'b0;
    do_promote = 1'b0;
    do_op      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.cmd > CMD_FLUSH_EVERY) begin
            state_next = S_DONE;
          end else if ((req.cmd == CMD_FLUSH || req.cmd == CMD_FLUSH_EVERY) &&
                       !writer_present) begin
            state_next = S_DONE;
          end else if (req.cmd == CMD_FLUSH_EVERY) begin
            state_next = S_FA_FIND;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (match || scan_last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_DONE;
        priority if (cmd_q <= CMD_LOCK) begin
          if (hit_q) begin
            do_promote = 1'b1;
            do_op      = 1'b1;
          end else if (free_v) begin
            state_next = S_FILL;
          end else if (unp_v) begin
            state_next = (slot_dirty[unp_idx] && writer_present) ? S_WB : S_FILL;
          end
        end else if (cmd_q == CMD_UNLOCK || cmd_q == CMD_MARK_DIRTY) begin
          if (hit_q) begin
            do_promote = 1'b1;
            do_op      = 1'b1;
          end
        end else if (cmd_q == CMD_FLUSH) begin
          if (hit_q && slot_dirty[s_q]) begin
            state_next = S_WB;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_WB: begin
        if (out_free) begin
          emit       = 1'b1;
          e_kind     = KIND_WRITEBACK;
          e_key      = wb_key;
          state_next = (cmd_q == CMD_FLUSH) ? S_DONE : S_FILL;
        end
      end
      S_FILL: begin
        if (out_free) begin
          emit       = 1'b1;
          e_kind     = KIND_FILL;
          e_zf       = !loader_present;
          ram_we     = 1'b1;
          do_promote = 1'b1;
          do_op      = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          e_status   = status_q;
          e_p        = qp_q;
          e_d        = qd_q;
          state_next = S_IDLE;
        end
      end
      S_FA_FIND: begin
        if (fa_any) begin
          state_next = S_FA_EMIT;
        end else if (fa_rank == TOP_RANK) begin
          state_next = S_DONE;
        end
      end
      S_FA_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          e_kind     = KIND_WRITEBACK;
          e_slot     = fa_slot;
          e_key      = ram_rdata;
          state_next = (fa_rank == TOP_RANK) ? S_DONE : S_FA_FIND;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (emit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.kind       <= e_kind;
      rsp.slot       <= 4'(e_slot);
      rsp.target_key <= e_key;
      rsp.zero_fill  <= e_zf;
      rsp.status     <= e_status;
      rsp.is_pinned  <= e_p;
      rsp.dirty_flag <= e_d;
      rsp.last       <= (e_kind == KIND_DONE);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= 5'd16;
      writer_present <= 1'b1;
      loader_present <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ACTIVE_ENTRIES: active_entries <= cfg.data;
        REG_WRITER_PRESENT: writer_present <= cfg.data[0];
        REG_LOADER_PRESENT: loader_present <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Command datapath: scan, victim tracking and decision.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_v <= 1'b0;
    end else begin
      cmp_v <= issue;
    end
    if (issue) begin
      scan_idx <= scan_idx + AW'(1);
    end
    cmp_idx <= IW'(scan_idx);
    unique case (state)
      S_IDLE: begin
        cmd_q    <= req.cmd;
        key_q    <= (req.cmd == CMD_FLUSH_EVERY) ? 64'd0 : req.key;
        s_q      <= '0;
        status_q <= (req.cmd > CMD_FLUSH_EVERY) ? ST_NOT_SUPPORTED :
                    ((req.cmd == CMD_FLUSH || req.cmd == CMD_FLUSH_EVERY) &&
                     !writer_present) ? ST_NOT_SUPPORTED : ST_OK;
        qp_q     <= 1'b0;
        qd_q     <= 1'b0;
        hit_q    <= 1'b0;
        free_v   <= 1'b0;
        unp_v    <= 1'b0;
        scan_idx <= '0;
        fa_rank  <= '0;
      end
      S_SCAN: begin
        if (match) begin
          hit_q <= 1'b1;
          s_q   <= cmp_idx;
        end else if (cmp_v) begin
          if (!slot_used[cmp_idx] && (!free_v || lru_rank[cmp_idx] < free_rank)) begin
            free_v    <= 1'b1;
            free_idx  <= cmp_idx;
            free_rank <= lru_rank[cmp_idx];
          end
          if (pin_count[cmp_idx] == '0 && (!unp_v || lru_rank[cmp_idx] < unp_rank)) begin
            unp_v    <= 1'b1;
            unp_idx  <= cmp_idx;
            unp_rank <= lru_rank[cmp_idx];
            unp_key  <= ram_rdata;
          end
        end
      end
      S_DECIDE: begin
        priority if (cmd_q <= CMD_LOCK) begin
          if (!hit_q) begin
            if (free_v) begin
              s_q <= free_idx;
            end else if (unp_v) begin
              s_q    <= unp_idx;
              wb_key <= unp_key;
            end else begin
              status_q <= (cmd_q == CMD_READ || cmd_q == CMD_WRITE) ? ST_FULL
                                                                  : ST_NOT_FOUND;
            end
          end
        end else if (cmd_q == CMD_QUERY) begin
          qp_q <= hit_q && (pin_count[s_q] != '0);
          qd_q <= hit_q && slot_dirty[s_q];
        end else if (cmd_q == CMD_INVALIDATE) begin
          if (hit_q && pin_count[s_q] != '0) begin
            status_q <= ST_BUSY;
          end
        end else if (cmd_q == CMD_FLUSH) begin
          wb_key <= key_q;
        end else begin
          if (!hit_q) begin
            status_q <= ST_NOT_FOUND;
          end
        end
      end
      S_FA_FIND: begin
        if (fa_any) begin
          fa_slot <= fa_idx;
        end else if (fa_rank != TOP_RANK) begin
          fa_rank <= fa_rank + IW'(1);
        end
      end
      S_FA_EMIT: begin
        if (out_free && fa_rank != TOP_RANK) begin
          fa_rank <= fa_rank + IW'(1);
        end
      end
      default: ;
    endcase
  end

  // Slot flags, pin counts and LRU ranks.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_used[i]  <= 1'b0;
        slot_dirty[i] <= 1'b0;
        pin_count[i]  <= '0;
        lru_rank[i]   <= IW'(i);
      end
    end else begin
      if (do_promote) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (lru_rank[i] > lru_rank[s_q]) begin
            lru_rank[i] <= lru_rank[i] - IW'(1);
          end
        end
        lru_rank[s_q] <= TOP_RANK;
      end
      if (state == S_DECIDE && cmd_q == CMD_INVALIDATE && hit_q &&
          pin_count[s_q] == '0) begin
        slot_used[s_q]  <= 1'b0;
        slot_dirty[s_q] <= 1'b0;
      end
      if (state == S_WB && out_free) begin
        slot_dirty[s_q] <= 1'b0;
      end
      if (state == S_FA_EMIT && out_free) begin
        slot_dirty[fa_slot] <= 1'b0;
      end
      // A filled slot starts clean; a write marks it dirty below instead.
      if (state == S_FILL && out_free) begin
        slot_used[s_q] <= 1'b1;
        if (cmd_q != CMD_WRITE) begin
          slot_dirty[s_q] <= 1'b0;
        end
      end
      if (do_op) begin
        if (cmd_q == CMD_WRITE || cmd_q == CMD_MARK_DIRTY) begin
          slot_dirty[s_q] <= 1'b1;
        end else if (cmd_q == CMD_LOCK) begin
          if (pin_count[s_q] != '1) begin
            pin_count[s_q] <= pin_count[s_q] + PIN_BITS'(1);
          end
        end else if (cmd_q == CMD_UNLOCK) begin
          if (pin_count[s_q] != '0) begin
            pin_count[s_q] <= pin_count[s_q] - PIN_BITS'(1);
          end
        end
      end
    end
  end

  // The LRU ranks stay a permutation, so exactly one slot is newest.
  a_one_newest: assert property (@(posedge clk) disable iff (rst) $onehot(rank_top))
    else $error("LRU ranks lost their newest slot");

  a_last_is_done: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.last |-> rsp.kind == KIND_DONE)
    else $error("last flag on a non-done transaction");

  a_fill_clean: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.kind == KIND_FILL |-> rsp.status == ST_OK && !rsp.last)
    else $error("fill transaction carries status or last");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("command accepted while another is in progress");

  a_fill_writes_key: assert property (@(posedge clk) disable iff (rst)
    state == S_FILL && out_free |=> state == S_DONE && slot_used[s_q])
    else $error("filled slot not marked used");

endmodule

// ----- rtl/lpwcd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpwcd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/tb_if_note.sv -----
`timescale 1ns / 100ps
// Shared types for the cache directory testbench: one expected result transaction and one directed table row.
// Depends on lpwcd_pkg.
package tb_dir_pkg;
  import lpwcd_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [63:0] target_key;
    logic        zero_fill;
    logic [2:0]  status;
    logic        is_pinned;
    logic        dirty_flag;
    logic        last;
  } dir_result_t;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [63:0] key;
    logic        has_golden;
    logic [2:0]  golden_status;
  } dir_row_t;
endpackage

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of lru_pinned_writeback_cache_directory.
// Depends on lpwcd_pkg, tb_dir_pkg, the three channel interfaces and the RTL.
module tb;
  import lpwcd_pkg::*;
  import tb_dir_pkg::*;

  localparam int SLOTS = 16;
  localparam int PIN_MAX = 255;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst;

  lpwcd_req_if req ();
  lpwcd_rsp_if rsp ();
  lpwcd_cfg_if cfg ();

  lru_pinned_writeback_cache_directory u_top (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source),
    .cfg(cfg.sink)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mirror of the directory state, kept by the predictor.
  logic [63:0] m_key   [SLOTS];
  logic        m_used  [SLOTS];
  logic        m_dirty [SLOTS];
  int unsigned m_pins  [SLOTS];
  int unsigned m_rank  [SLOTS];
  int unsigned m_active_reg;
  logic        m_writer;
  logic        m_loader;

  dir_result_t pending_results[$];
  int          fail_count;
  int          results_seen;
  int          writebacks_seen;
  int          fills_seen;
  int          idle_cycles;
  bit          rsp_stall_en;

  // Keys come mostly from a small pool so that hits, misses and evictions all happen.
  logic [63:0] key_pool[24];

  function automatic int active_slots();
    int a;
    a = m_active_reg;
    if (a < 1) a = 1;
    if (a > SLOTS) a = SLOTS;
    return a;
  endfunction

  function automatic int find_slot(logic [63:0] k);
    for (int i = 0; i < active_slots(); i++)
      if (m_used[i] && m_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void make_newest(int s);
    int unsigned r;
    r = m_rank[s];
    for (int i = 0; i < SLOTS; i++)
      if (m_rank[i] > r) m_rank[i]--;
    m_rank[s] = SLOTS - 1;
  endfunction

  function automatic void push_result(logic [1:0] kind, int s, logic [63:0] k,
                                      logic zf, logic [2:0] st, logic p, logic d,
                                      logic lst);
    dir_result_t r;
    r.kind = kind;
    r.slot = s[3:0];
    r.target_key = k;
    r.zero_fill = zf;
    r.status = st;
    r.is_pinned = p;
    r.dirty_flag = d;
    r.last = lst;
    pending_results.push_back(r);
  endfunction

  // Brings a key into the directory: hit, fill of a free slot, or eviction.
  // Returns the slot, or -1 when every active slot is pinned.
  function automatic int bring_in(logic [63:0] k);
    int s;
    s = find_slot(k);
    if (s >= 0) begin
      make_newest(s);
      return s;
    end
    for (int i = 0; i < active_slots(); i++)
      if (!m_used[i] && (s < 0 || m_rank[i] < m_rank[s])) s = i;
    if (s < 0) begin
      for (int i = 0; i < active_slots(); i++)
        if (m_pins[i] == 0 && (s < 0 || m_rank[i] < m_rank[s])) s = i;
      if (s < 0) return -1;
      if (m_dirty[s] && m_writer)
        push_result(KIND_WRITEBACK, s, m_key[s], 1'b0, ST_OK, 1'b0, 1'b0, 1'b0);
      m_dirty[s] = 1'b0;
    end else begin
      m_used[s] = 1'b1;
    end
    m_key[s] = k;
    push_result(KIND_FILL, s, k, !m_loader, ST_OK, 1'b0, 1'b0, 1'b0);
    make_newest(s);
    return s;
  endfunction

  // Predicts every result transaction of one command and updates the mirror.
  function automatic void predict_command(logic [3:0] cmd, logic [63:0] k);
    int s;
    logic [2:0] st;
    s = 0;
    st = ST_OK;
    case (cmd)
      CMD_GET, CMD_READ, CMD_WRITE, CMD_LOCK: begin
        s = bring_in(k);
        if (s < 0) begin
          st = (cmd == CMD_READ || cmd == CMD_WRITE) ? ST_FULL : ST_NOT_FOUND;
          s = 0;
        end else if (cmd == CMD_WRITE) begin
          m_dirty[s] = 1'b1;
        end else if (cmd == CMD_LOCK) begin
          if (m_pins[s] < PIN_MAX) m_pins[s]++;
        end
      end
      CMD_UNLOCK, CMD_MARK_DIRTY: begin
        s = find_slot(k);
        if (s < 0) begin
          st = ST_NOT_FOUND;
          s = 0;
        end else begin
          make_newest(s);
          if (cmd == CMD_UNLOCK) begin
            if (m_pins[s] > 0) m_pins[s]--;
          end else begin
            m_dirty[s] = 1'b1;
          end
        end
      end
      CMD_QUERY: begin
        s = find_slot(k);
        push_result(KIND_DONE, s >= 0 ? s : 0, k, 1'b0, ST_OK,
                    s >= 0 && m_pins[s] > 0, s >= 0 && m_dirty[s], 1'b1);
        return;
      end
      CMD_INVALIDATE: begin
        s = find_slot(k);
        if (s < 0) begin
          s = 0;
        end else if (m_pins[s] > 0) begin
          st = ST_BUSY;
        end else begin
          m_used[s] = 1'b0;
          m_dirty[s] = 1'b0;
        end
      end
      CMD_FLUSH: begin
        if (!m_writer) begin
          st = ST_NOT_SUPPORTED;
        end else begin
          s = find_slot(k);
          if (s < 0) begin
            s = 0;
          end else if (m_dirty[s]) begin
            push_result(KIND_WRITEBACK, s, m_key[s], 1'b0, ST_OK, 1'b0, 1'b0, 1'b0);
            m_dirty[s] = 1'b0;
          end
        end
      end
      CMD_FLUSH_EVERY: begin
        k = '0;
        if (!m_writer) begin
          st = ST_NOT_SUPPORTED;
        end else begin
          // Oldest rank first.
          for (int r = 0; r < SLOTS; r++)
            for (int i = 0; i < active_slots(); i++)
              if (m_rank[i] == r && m_used[i] && m_dirty[i]) begin
                push_result(KIND_WRITEBACK, i, m_key[i], 1'b0, ST_OK,
                            1'b0, 1'b0, 1'b0);
                m_dirty[i] = 1'b0;
              end
        end
      end
      default: st = ST_NOT_SUPPORTED;
    endcase
    push_result(KIND_DONE, s, k, 1'b0, st, 1'b0, 1'b0, 1'b1);
  endfunction

  // Short gaps mostly, an occasional long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // The block is not ready again right after it accepts a command, so dropping
  // valid between commands costs nothing.
  task automatic send_command(logic [3:0] cmd, logic [63:0] k);
    int gap;
    gap = pick_gap();
    @(posedge clk);
    repeat (gap) @(posedge clk);
    predict_command(cmd, k);
    req.valid <= 1'b1;
    req.cmd <= cmd;
    req.key <= k;
    do @(posedge clk); while (!req.ready);
    req.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    // Let a command that produces no more results settle before reconfiguring.
    repeat (24) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [4:0] value);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      REG_ACTIVE_ENTRIES: m_active_reg = value;
      REG_WRITER_PRESENT: m_writer = value[0];
      default:            m_loader = value[0];
    endcase
  endtask

  task automatic configure(logic [4:0] active, logic writer, logic loader);
    wait_drained();
    write_register(REG_ACTIVE_ENTRIES, active);
    write_register(REG_WRITER_PRESENT, {4'd0, writer});
    write_register(REG_LOADER_PRESENT, {4'd0, loader});
  endtask

  // Mostly key-pool commands in working order, some with fully random keys and
  // unknown codes as noise.
  task automatic random_command();
    int roll;
    logic [3:0] cmd;
    logic [63:0] k;
    roll = $urandom_range(0, 99);
    if (roll < 30) cmd = ($urandom_range(0, 1) != 0) ? CMD_GET : CMD_READ;
    else if (roll < 45) cmd = CMD_WRITE;
    else if (roll < 55) cmd = CMD_LOCK;
    else if (roll < 65) cmd = CMD_UNLOCK;
    else if (roll < 71) cmd = CMD_MARK_DIRTY;
    else if (roll < 79) cmd = CMD_QUERY;
    else if (roll < 86) cmd = CMD_INVALIDATE;
    else if (roll < 92) cmd = CMD_FLUSH;
    else if (roll < 96) cmd = CMD_FLUSH_EVERY;
    else cmd = 4'($urandom_range(10, 15));
    if ($urandom_range(0, 9) == 0) k = {$urandom, $urandom};
    else k = key_pool[$urandom_range(0, 23)];
    send_command(cmd, k);
  endtask

  // Directed table; rows with has_golden carry a status visible at a glance.
  dir_row_t directed_rows[] = '{
    '{CMD_QUERY,       64'h0,                  1'b1, ST_OK},
    '{CMD_UNLOCK,      64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_NOT_FOUND},
    '{CMD_MARK_DIRTY,  64'h1234,               1'b1, ST_NOT_FOUND},
    '{CMD_INVALIDATE,  64'h55,                 1'b1, ST_OK},
    '{CMD_GET,         64'h0,                  1'b0, ST_OK},
    '{CMD_WRITE,       64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_OK},
    '{CMD_READ,        64'hAAAA_5555_AAAA_5555, 1'b0, ST_OK},
    '{CMD_LOCK,        64'h0,                  1'b0, ST_OK},
    '{CMD_QUERY,       64'h0,                  1'b0, ST_OK},
    '{CMD_INVALIDATE,  64'h0,                  1'b1, ST_BUSY},
    '{CMD_UNLOCK,      64'h0,                  1'b1, ST_OK},
    '{CMD_UNLOCK,      64'h0,                  1'b1, ST_OK},
    '{CMD_MARK_DIRTY,  64'hAAAA_5555_AAAA_5555, 1'b1, ST_OK},
    '{CMD_QUERY,       64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_OK},
    '{CMD_FLUSH,       64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_OK},
    '{CMD_FLUSH,       64'h7777,               1'b1, ST_OK},
    '{CMD_FLUSH_EVERY, 64'h0,                  1'b0, ST_OK},
    '{CMD_INVALIDATE,  64'h0,                  1'b1, ST_OK},
    '{4'd10,           64'h1,                  1'b1, ST_NOT_SUPPORTED},
    '{4'd15,           64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_NOT_SUPPORTED}
  };

  // Result side: random stalls, comparison against the oldest expectation.
  always @(posedge clk) begin
    dir_result_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (rsp.kind == KIND_WRITEBACK) writebacks_seen++;
        if (rsp.kind == KIND_FILL) fills_seen++;
        if (pending_results.size() == 0) begin
          $error("unexpected result transaction kind=%0d slot=%0d", rsp.kind, rsp.slot);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (rsp.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, rsp.kind);
            fail_count++;
          end
          if (rsp.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, rsp.slot);
            fail_count++;
          end
          if (rsp.target_key !== want.target_key) begin
            $error("target_key: expected %h, got %h", want.target_key, rsp.target_key);
            fail_count++;
          end
          if (rsp.zero_fill !== want.zero_fill) begin
            $error("zero_fill: expected %0b, got %0b", want.zero_fill, rsp.zero_fill);
            fail_count++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fail_count++;
          end
          if (rsp.is_pinned !== want.is_pinned) begin
            $error("is_pinned: expected %0b, got %0b", want.is_pinned, rsp.is_pinned);
            fail_count++;
          end
          if (rsp.dirty_flag !== want.dirty_flag) begin
            $error("dirty_flag: expected %0b, got %0b", want.dirty_flag, rsp.dirty_flag);
            fail_count++;
          end
          if (rsp.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, rsp.last);
            fail_count++;
          end
        end
      end
      rsp.ready <= rsp_stall_en ? ($urandom_range(0, 99) < 65) : 1'b1;
    end
  end

  // Stall the receiver in stretches, with long stretches of no stalling.
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) rsp_stall_en <= ~rsp_stall_en;
  end

  // Watchdog on cycles without any accepted transaction. Results that nobody
  // expects do not count as progress, so a runaway result stream also ends the run.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) ||
        (rsp.valid && rsp.ready && pending_results.size() != 0) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    dir_result_t golden;
    int n_random;
    rst = 1'b1;
    req.valid = 1'b0;
    req.cmd = CMD_GET;
    req.key = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_ACTIVE_ENTRIES;
    cfg.data = '0;
    rsp_stall_en = 1'b0;
    fail_count = 0;
    results_seen = 0;
    writebacks_seen = 0;
    fills_seen = 0;
    idle_cycles = 0;
    for (int i = 0; i < SLOTS; i++) begin
      m_key[i] = '0;
      m_used[i] = 1'b0;
      m_dirty[i] = 1'b0;
      m_pins[i] = 0;
      m_rank[i] = i;
    end
    m_active_reg = 16;
    m_writer = 1'b1;
    m_loader = 1'b1;
    for (int i = 0; i < 24; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset settings.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].has_golden) begin
        send_command(directed_rows[i].cmd, directed_rows[i].key);
        // The typed-in status must agree with what the predictor queued last.
        golden = pending_results[pending_results.size() - 1];
        if (golden.status !== directed_rows[i].golden_status) begin
          $error("status: expected %0d, got %0d (table row %0d)",
                 directed_rows[i].golden_status, golden.status, i);
          fail_count++;
        end
      end else begin
        send_command(directed_rows[i].cmd, directed_rows[i].key);
      end
    end

    // One active slot, pinned several times over, with zero fills.
    configure(5'd1, 1'b1, 1'b0);
    for (int i = 0; i < 3; i++) send_command(CMD_LOCK, 64'h42);
    // Single slot pinned: a miss finds no victim.
    send_command(CMD_READ, 64'h43);
    send_command(CMD_GET, 64'h43);
    for (int i = 0; i < 3; i++) send_command(CMD_UNLOCK, 64'h42);

    // Random phases over several register settings, extremes included.
    n_random = 0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: configure(5'd16, 1'b1, 1'b1);
        1: configure(5'd2, 1'b0, 1'b1);
        2: configure(5'd31, 1'b1, 1'b0);
        3: configure(5'd0, 1'b0, 1'b0);
        4: configure(5'($urandom_range(3, 15)), 1'($urandom), 1'($urandom));
        default: configure(5'd16, 1'b1, 1'b1);
      endcase
      repeat (29) begin
        random_command();
        n_random++;
      end
    end

    wait_drained();
    $display("Ran %0d random commands after the directed table over six settings.",
             n_random);
    $display("Checked %0d result transactions: %0d writebacks, %0d fills.",
             results_seen, writebacks_seen, fills_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
